@@ rtl/core/bounded_ordered_list_engine_defines.svh @@
// assertion macros for the ordered list engine
// used by the top level only
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
// assertion checked on the rising clock edge, skipped while in reset
`define BOLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assertion that also holds during reset
`define BOLE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/bole_pkg.sv @@
// shared types and codes for the ordered list engine
// no dependencies
package bole_pkg;
    localparam logic [3:0] OP_INS_FRONT  = 4'd0;
    localparam logic [3:0] OP_INS_BACK   = 4'd1;
    localparam logic [3:0] OP_INS_AT     = 4'd2;
    localparam logic [3:0] OP_INS_SORTED = 4'd3;
    localparam logic [3:0] OP_RM_FRONT   = 4'd4;
    localparam logic [3:0] OP_RM_BACK    = 4'd5;
    localparam logic [3:0] OP_RM_AT      = 4'd6;
    localparam logic [3:0] OP_RD_FRONT   = 4'd7;
    localparam logic [3:0] OP_RD_BACK    = 4'd8;
    localparam logic [3:0] OP_RD_AT      = 4'd9;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        cmp_en;   // compare the value against own slot
        logic        ins_en;   // open gap at the index and write the value
        logic        rm_en;    // close gap at the index
        logic        rd_en;    // drive own slot onto the read bus if at the index
    } t_cell_ctl;
endpackage

@@ rtl/core/bole_cell.sv @@
// one slot of the list chain: holds one value, shifts with its neighbours
// uses bole_pkg
module bole_cell #(
    parameter int IW = 8
) (
    input  logic                  i_clk,
    input  logic [IW-1:0]         i_my_idx,
    input  bole_pkg::t_cell_ctl   i_ctl,
    input  logic [IW-1:0]         i_idx,
    input  logic [31:0]           i_value,
    input  logic [31:0]           i_left,
    input  logic [31:0]           i_right,
    input  logic [IW:0]           i_count,
    output logic [31:0]           o_value,
    output logic                  o_less,
    output logic                  o_hit
);
    logic [31:0] r_val;
    logic        w_live;

    assign w_live  = {1'b0, i_my_idx} < i_count;
    assign o_value = r_val;
    // slot holds a live element smaller than the probe value
    assign o_less  = i_ctl.cmp_en && w_live && ($signed(i_value) > $signed(r_val));
    assign o_hit   = i_ctl.rd_en && (i_my_idx == i_idx);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (i_my_idx == i_idx) r_val <= i_value;
            else if (i_my_idx > i_idx) r_val <= i_left;
        end else if (i_ctl.rm_en) begin
            if (i_my_idx >= i_idx) r_val <= i_right;
        end
    end
endmodule

@@ rtl/core/bounded_ordered_list_engine.sv @@
// ordered list engine top level: controller plus chain of slot cells
// uses bole_pkg, bole_cell and the assertion macro header
//
// usage
//   input channel i_valid/o_ready carries one command beat (opcode, position,
//   value); output channel o_valid/i_ready returns one result beat per command
//   with value, status and element count after the command.
//   the result beat is presented once the command has passed broadcast compare
//   and decode, shift/read in the cell chain and the result register.
//   the cells shift in parallel so latency does not depend on list length.
//   one command is in flight at a time; the next is taken once the result
//   register is free, so a stalled receiver holds the result and blocks input.
//   the per-cell compare result is collected by a priority encode over all
//   cells for sorted insert.
//   reset clears the element count and the controller; slot contents are
//   left as they are and are only read below the count.
`include "bounded_ordered_list_engine_defines.svh"
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_position,
    input  logic signed [31:0] i_value_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_value_out,
    output logic [1:0]  o_status,
    output logic [8:0]  o_element_count
);
    localparam int IW = (CAPACITY > 256) ? $clog2(CAPACITY) : 8;
    localparam int CW = IW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_op;
    logic [IW-1:0] r_pos;
    logic [31:0] r_val;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [1:0]  r_st, n_st;
    logic        r_act, n_act;
    logic        r_ovalid;
    logic [31:0] r_vout;
    logic [1:0]  r_ost;
    logic [CW-1:0] r_ocount;

    bole_pkg::t_cell_ctl w_ctl;
    logic [31:0] w_vals [CAPACITY+1];
    logic [CAPACITY-1:0] w_less, w_hit;
    logic [31:0] w_rd;
    logic [CW-1:0] w_sidx;
    logic [CW-1:0] w_pos;
    logic w_empty, w_full;

    assign w_pos   = CW'(r_pos);
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count >= CW'(CAPACITY));
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    assign w_ctl.cmp_en = (r_state == S_CMP) && (r_op == bole_pkg::OP_INS_SORTED);
    assign w_ctl.ins_en = (r_state == S_EXEC) && r_act && (r_op <= bole_pkg::OP_INS_SORTED);
    assign w_ctl.rm_en  = (r_state == S_EXEC) && r_act && (r_op >= bole_pkg::OP_RM_FRONT)
                          && (r_op <= bole_pkg::OP_RM_AT);
    assign w_ctl.rd_en  = (r_state == S_EXEC) && r_act;

    assign w_vals[CAPACITY] = '0;
    genvar g;
    for (g = 0; g < CAPACITY; g++) begin : g_cell
        bole_cell #(.IW(IW)) u_cell (
            .i_clk    (i_clk),
            .i_my_idx (IW'(g)),
            .i_ctl    (w_ctl),
            .i_idx    (r_idx),
            .i_value  (r_val),
            .i_left   ((g == 0) ? r_val : w_vals[(g == 0) ? 0 : g-1]),
            .i_right  (w_vals[g+1]),
            .i_count  (r_count),
            .o_value  (w_vals[g]),
            .o_less   (w_less[g]),
            .o_hit    (w_hit[g])
        );
    end

    // last smaller element, plus one
    always_comb begin
        w_sidx = '0;
        for (int k = 0; k < CAPACITY; k++)
            if (w_less[k]) w_sidx = CW'(k + 1);
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++)
            if (w_hit[k]) w_rd = w_vals[k];
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_st    = r_st;
        n_act   = r_act;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXEC;
                n_st  = bole_pkg::ST_OK;
                n_act = 1'b0;
                case (r_op)
                    bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK,
                    bole_pkg::OP_INS_SORTED: begin
                        if (w_full) n_st = bole_pkg::ST_FULL;
                        else n_act = 1'b1;
                        if (r_op == bole_pkg::OP_INS_FRONT) n_idx = '0;
                        else if (r_op == bole_pkg::OP_INS_BACK) n_idx = r_count[IW-1:0];
                        else n_idx = w_sidx[IW-1:0];
                    end
                    bole_pkg::OP_INS_AT: begin
                        n_idx = r_pos;
                        if (w_pos > r_count) n_st = bole_pkg::ST_BADPOS;
                        else if (w_full) n_st = bole_pkg::ST_FULL;
                        else n_act = 1'b1;
                    end
                    bole_pkg::OP_RM_FRONT, bole_pkg::OP_RD_FRONT: begin
                        n_idx = '0;
                        if (w_empty) n_st = bole_pkg::ST_EMPTY;
                        else n_act = 1'b1;
                    end
                    bole_pkg::OP_RM_BACK, bole_pkg::OP_RD_BACK: begin
                        n_idx = IW'(r_count - CW'(1));
                        if (w_empty) n_st = bole_pkg::ST_EMPTY;
                        else n_act = 1'b1;
                    end
                    bole_pkg::OP_RM_AT: begin
                        n_idx = r_pos;
                        if (w_empty) n_st = bole_pkg::ST_EMPTY;
                        else if (w_pos >= r_count) n_st = bole_pkg::ST_BADPOS;
                        else n_act = 1'b1;
                    end
                    bole_pkg::OP_RD_AT: begin
                        n_idx = r_pos;
                        if (w_pos >= r_count) n_st = bole_pkg::ST_BADPOS;
                        else n_act = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (w_ctl.ins_en) n_count = r_count + CW'(1);
                else if (w_ctl.rm_en) n_count = r_count - CW'(1);
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_act    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_act   <= n_act;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_st  <= n_st;
        if (i_valid && o_ready) begin
            r_op  <= i_opcode;
            r_pos <= IW'(i_position);
            r_val <= i_value_in;
        end
        if (r_state == S_EXEC) begin
            r_vout <= (r_act && (r_op >= bole_pkg::OP_RM_FRONT)) ? w_rd : '0;
        end
        if (r_state == S_DONE) begin
            r_ost    <= r_st;
            r_ocount <= r_count;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_value_out     = r_vout;
    assign o_status        = r_ost;
    assign o_element_count = r_ocount[8:0];

    `BOLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count beyond capacity")
    `BOLE_ASSERT(a_one_op, i_clk, i_rst_n, !(w_ctl.ins_en && w_ctl.rm_en), "insert and remove together")
    `BOLE_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_ready, "accept while busy")
    `BOLE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_ovalid), "reset")
endmodule

@@ verif/bounded_ordered_list_engine_tb.sv @@
// testbench for the bounded ordered list engine: commands in, one result beat each
// keeps its own copy of the list to work out every result; uses bole_pkg
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
    localparam int CAPACITY = 256;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [7:0]         position;
        logic signed [31:0] value_in;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic [8:0]         element_count;
    } t_res;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [3:0]         in_opcode = '0;
    logic [7:0]         in_position = '0;
    logic signed [31:0] in_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] out_value;
    logic [1:0]         out_status;
    logic [8:0]         out_count;

    t_cmd pending_cmds[$];
    t_res expected_res[$];
    logic signed [31:0] shadow_list[$];
    int   error_count = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   hold_off = 1'b0;

    always #5 clk = ~clk;

    bounded_ordered_list_engine #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_opcode        (in_opcode),
        .i_position      (in_position),
        .i_value_in      (in_value),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_value_out     (out_value),
        .o_status        (out_status),
        .o_element_count (out_count)
    );

    // works out the result of one command and updates the shadow list
    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        int   n;
        int   idx;
        n = shadow_list.size();
        r = '0;
        r.status = bole_pkg::ST_OK;
        case (c.opcode)
            bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK, bole_pkg::OP_INS_SORTED: begin
                if (n >= CAPACITY) begin
                    r.status = bole_pkg::ST_FULL;
                end else if (c.opcode == bole_pkg::OP_INS_FRONT) begin
                    shadow_list.push_front(c.value_in);
                end else if (c.opcode == bole_pkg::OP_INS_BACK) begin
                    shadow_list.push_back(c.value_in);
                end else begin
                    idx = 0;
                    for (int i = 0; i < n; i++)
                        if (c.value_in > shadow_list[i]) idx = i + 1;
                    shadow_list.insert(idx, c.value_in);
                end
            end
            bole_pkg::OP_INS_AT: begin
                if (c.position > n) r.status = bole_pkg::ST_BADPOS;
                else if (n >= CAPACITY) r.status = bole_pkg::ST_FULL;
                else shadow_list.insert(c.position, c.value_in);
            end
            bole_pkg::OP_RM_FRONT: begin
                if (n == 0) r.status = bole_pkg::ST_EMPTY;
                else r.value_out = shadow_list.pop_front();
            end
            bole_pkg::OP_RM_BACK: begin
                if (n == 0) r.status = bole_pkg::ST_EMPTY;
                else r.value_out = shadow_list.pop_back();
            end
            bole_pkg::OP_RM_AT: begin
                if (n == 0) begin
                    r.status = bole_pkg::ST_EMPTY;
                end else if (c.position >= n) begin
                    r.status = bole_pkg::ST_BADPOS;
                end else begin
                    r.value_out = shadow_list[c.position];
                    shadow_list.delete(c.position);
                end
            end
            bole_pkg::OP_RD_FRONT: begin
                if (n == 0) r.status = bole_pkg::ST_EMPTY;
                else r.value_out = shadow_list[0];
            end
            bole_pkg::OP_RD_BACK: begin
                if (n == 0) r.status = bole_pkg::ST_EMPTY;
                else r.value_out = shadow_list[n - 1];
            end
            bole_pkg::OP_RD_AT: begin
                if (c.position >= n) r.status = bole_pkg::ST_BADPOS;
                else r.value_out = shadow_list[c.position];
            end
            default: ;
        endcase
        r.element_count = 9'(shadow_list.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic t_cmd mk_cmd(logic [3:0] op, int pos, logic [31:0] val);
        t_cmd c;
        c.opcode = op;
        c.position = 8'(pos);
        c.value_in = val;
        return c;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    // driver: one beat at a time from the queue, random gap before each
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_ready) begin
            // holding the beat
        end else begin
            if (in_valid) begin
                expected_res.push_back(apply_cmd(mk_cmd(in_opcode, in_position, in_value)));
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            end
            if (send_gap > 0 || hold_off || pending_cmds.size() == 0) begin
                in_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                t_cmd c;
                c = pending_cmds.pop_front();
                in_valid    <= 1'b1;
                in_opcode   <= c.opcode;
                in_position <= c.position;
                in_value    <= c.value_in;
            end
        end
    end

    // monitor: random stall on ready, compare each accepted result beat
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected beat", out_value, 0);
                end else begin
                    t_res e;
                    e = expected_res.pop_front();
                    if (out_value !== e.value_out)
                        report_mismatch("value_out", out_value, e.value_out);
                    if (out_status !== e.status)
                        report_mismatch("status", out_status, e.status);
                    if (out_count !== e.element_count)
                        report_mismatch("element_count", out_count, e.element_count);
                end
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            end
            if (recv_gap > 0) begin
                out_ready <= 1'b0;
                recv_gap--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int fill;
        // directed: empty errors, extremes, every opcode, sort ties
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_FRONT, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_BACK, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_AT, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_FRONT, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_BACK, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_AT, 8'hff, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_AT, 1, 5));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_SORTED, 0, 32'h7fff_ffff));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_SORTED, 0, 32'h8000_0000));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_SORTED, 0, 7));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_SORTED, 0, 7));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_FRONT, 0, 32'hffff_ffff));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_BACK, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_AT, 6, 32'h1234_5678));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_AT, 2, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_AT, 7, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_AT, 3, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_FRONT, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_BACK, 0, 0));
        pending_cmds.push_back(mk_cmd(4'hf, 8'haa, 32'h5555_5555));
        pending_cmds.push_back(mk_cmd(4'ha, 8'h55, 32'haaaa_aaaa));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_FRONT, 0, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_BACK, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // fill to capacity, then push against the full list
        // positions stay within the count so every insert lands until full
        fill = 0;
        while (fill < 300) begin
            pending_cmds.push_back(mk_cmd(4'($urandom_range(0, 3)),
                                          $urandom_range(0, fill), rand_value()));
            fill++;
        end
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_INS_AT, 8'hff, 1));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RD_AT, 8'hff, 0));
        pending_cmds.push_back(mk_cmd(bole_pkg::OP_RM_AT, 8'hff, 0));
        for (int i = 0; i < 1450; i++) begin
            int r;
            logic [3:0] op;
            r = $urandom_range(0, 99);
            if (i < 700) op = r < 35 ? 4'($urandom_range(4, 6)) : 4'($urandom_range(0, 9));
            else if (i < 1000) op = r < 60 ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 9));
            else op = r < 3 ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
            // positions mostly inside the current range, sometimes anywhere
            pending_cmds.push_back(mk_cmd(op, r < 80 ? 8'($urandom_range(0, 40)) :
                                          8'($urandom()), rand_value()));
            if (i == 400) begin
                wait (pending_cmds.size() == 0 && !in_valid);
                hold_off = 1'b1;
                wait (expected_res.size() == 0);
                hold_off = 1'b0;
            end
        end
        wait (pending_cmds.size() == 0 && !in_valid);
        wait (expected_res.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0) $display("bounded_ordered_list_engine_tb: clean");
        else $display("bounded_ordered_list_engine_tb: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("bounded_ordered_list_engine_tb: errors");
        $finish;
    end
endmodule
